>>> rtl/circle_event_geometry_unit_defines.svh
// Assertion macros shared by the circle event geometry checker.
`ifndef CIRCLE_EVENT_GEOMETRY_UNIT_DEFINES_SVH
`define CIRCLE_EVENT_GEOMETRY_UNIT_DEFINES_SVH

// Condition implies consequence at the same edge, outside reset.
`define CEGU_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Condition must never hold outside reset.
`define CEGU_ASSERT_NEVER(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error("forbidden condition seen");

`endif

>>> rtl/cegu_pkg.sv
// Shared types and default constants for the circle event geometry unit.
package cegu_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int RESULT_WIDTH_DEF    = 32;

    // Control bits that travel alongside each item through the pipeline.
    typedef struct packed {
        logic valid;
        logic conv;
        logic degen;
        logic neg_x;
        logic neg_y;
    } cegu_ctl_t;

endpackage

>>> rtl/cegu_div_cell.sv
// One restoring-division cell: yields one quotient bit for both x and y.
module cegu_div_cell
    import cegu_pkg::*;
#(
    parameter int QW  = 51,
    parameter int DVW = 34,
    parameter int CW  = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cegu_ctl_t       ctl_in,
    input  logic [CW-1:0]   ax_in,
    input  logic [CW-1:0]   ay_in,
    input  logic [QW-1:0]   numx_in,
    input  logic [QW-1:0]   numy_in,
    input  logic [QW-1:0]   qx_in,
    input  logic [QW-1:0]   qy_in,
    input  logic [DVW:0]    remx_in,
    input  logic [DVW:0]    remy_in,
    input  logic [DVW-1:0]  dv_in,
    output cegu_ctl_t       ctl_out,
    output logic [CW-1:0]   ax_out,
    output logic [CW-1:0]   ay_out,
    output logic [QW-1:0]   numx_out,
    output logic [QW-1:0]   numy_out,
    output logic [QW-1:0]   qx_out,
    output logic [QW-1:0]   qy_out,
    output logic [DVW:0]    remx_out,
    output logic [DVW:0]    remy_out,
    output logic [DVW-1:0]  dv_out
);

    cegu_ctl_t       ctl_reg;
    logic [CW-1:0]   ax_reg, ay_reg;
    logic [QW-1:0]   numx_reg, numy_reg, qx_reg, qy_reg;
    logic [QW-1:0]   numx_next, numy_next, qx_next, qy_next;
    logic [DVW:0]    remx_reg, remy_reg, remx_next, remy_next;
    logic [DVW-1:0]  dv_reg;
    logic [DVW:0]    shx, shy, dvx;
    logic            gex, gey;

    // shift in the next numerator bit, trial subtract
    always_comb
    begin
        dvx       = {1'b0, dv_in};
        shx       = {remx_in[DVW-1:0], numx_in[QW-1]};
        shy       = {remy_in[DVW-1:0], numy_in[QW-1]};
        gex       = (shx >= dvx);
        gey       = (shy >= dvx);
        remx_next = gex ? (shx - dvx) : shx;
        remy_next = gey ? (shy - dvx) : shy;
        qx_next   = {qx_in[QW-2:0], gex};
        qy_next   = {qy_in[QW-2:0], gey};
        numx_next = {numx_in[QW-2:0], 1'b0};
        numy_next = {numy_in[QW-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_in;
        ay_reg   <= ay_in;
        numx_reg <= numx_next;
        numy_reg <= numy_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        remx_reg <= remx_next;
        remy_reg <= remy_next;
        dv_reg   <= dv_in;
    end

    assign ctl_out  = ctl_reg;
    assign ax_out   = ax_reg;
    assign ay_out   = ay_reg;
    assign numx_out = numx_reg;
    assign numy_out = numy_reg;
    assign qx_out   = qx_reg;
    assign qy_out   = qy_reg;
    assign remx_out = remx_reg;
    assign remy_out = remy_reg;
    assign dv_out   = dv_reg;

endmodule

>>> rtl/cegu_sqrt_cell.sv
// One digit-by-digit square root cell: consumes two radicand bits, yields one root bit.
module cegu_sqrt_cell
    import cegu_pkg::*;
#(
    parameter int SW = 34,
    parameter int RW = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cegu_ctl_t         ctl_in,
    input  logic [RW-1:0]     cx_in,
    input  logic [RW-1:0]     cy_in,
    input  logic [2*SW-1:0]   n_in,
    input  logic [SW+1:0]     rem_in,
    input  logic [SW-1:0]     res_in,
    output cegu_ctl_t         ctl_out,
    output logic [RW-1:0]     cx_out,
    output logic [RW-1:0]     cy_out,
    output logic [2*SW-1:0]   n_out,
    output logic [SW+1:0]     rem_out,
    output logic [SW-1:0]     res_out
);

    cegu_ctl_t          ctl_reg;
    logic [RW-1:0]      cx_reg, cy_reg;
    logic [2*SW-1:0]    n_reg, n_next;
    logic [SW+1:0]      rem_reg, rem_next, sh, trial;
    logic [SW-1:0]      res_reg, res_next;
    logic               ge;

    always_comb
    begin
        sh       = {rem_in[SW-1:0], n_in[2*SW-1:2*SW-2]};
        trial    = {res_in, 2'b01};
        ge       = (sh >= trial);
        rem_next = ge ? (sh - trial) : sh;
        res_next = {res_in[SW-2:0], ge};
        n_next   = {n_in[2*SW-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg  <= cx_in;
        cy_reg  <= cy_in;
        n_reg   <= n_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign ctl_out = ctl_reg;
    assign cx_out  = cx_reg;
    assign cy_out  = cy_reg;
    assign n_out   = n_reg;
    assign rem_out = rem_reg;
    assign res_out = res_reg;

endmodule

>>> rtl/circle_event_geometry_unit.sv
// Top level of the circle event geometry unit: circumcenter and lowest circle point.
//
// Fully pipelined; a new site triple can be started every clock cycle and busy
// never rises. Each transfer passes the front stages, the divider row, the
// offset, square and radius stages, the square root row and the output
// register, and comes out on the result ports flagged by a one-cycle strobe.
// The receiver cannot stall the result, so it must take every strobe. In the
// divider row each cell yields one quotient bit for the center offset, and in
// the square root row each cell yields one root bit for the radius. Collinear
// sites give degenerate = 1, converges = 0 and zero centers.
module circle_event_geometry_unit
    import cegu_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int RESULT_WIDTH    = RESULT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [15:0]                    left_x,
    input  logic [15:0]                    left_y,
    input  logic [15:0]                    mid_x,
    input  logic [15:0]                    mid_y,
    input  logic [15:0]                    right_x,
    input  logic [15:0]                    right_y,
    output logic                           strobe,
    output logic                           converges,
    output logic                           degenerate,
    output logic signed [RESULT_WIDTH-1:0] center_x,
    output logic signed [RESULT_WIDTH-1:0] center_y,
    output logic signed [RESULT_WIDTH-1:0] bottom_y
);

    localparam int F   = COORD_FRAC_BITS;
    localparam int RW  = RESULT_WIDTH;
    localparam int PW  = 2*F + 2;          // products of differences, determinant
    localparam int NW  = 3*F + 3;          // center numerators (signed)
    localparam int QW  = NW;               // dividend and quotient width
    localparam int DVW = 2*F + 2;          // divisor = twice |det|
    localparam int EW  = (QW + 2 > RW + 1) ? QW + 2 : RW + 1;
    localparam int SW  = RW + 2;           // root width
    localparam int BW  = RW + 3;           // bottom before clamping

    localparam logic signed [EW-1:0] SAT_HI_E = EW'((64'sd1 <<< (RW-1)) - 64'sd1);
    localparam logic signed [EW-1:0] SAT_LO_E = -SAT_HI_E - EW'(1);
    localparam logic signed [BW-1:0] SAT_HI_B = BW'((64'sd1 <<< (RW-1)) - 64'sd1);
    localparam logic signed [BW-1:0] SAT_LO_B = -SAT_HI_B - BW'(1);

    function automatic logic signed [RW-1:0] sat_e(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] c;
        c = (v > SAT_HI_E) ? SAT_HI_E : ((v < SAT_LO_E) ? SAT_LO_E : v);
        return RW'(c);
    endfunction

    function automatic logic signed [RW-1:0] sat_b(input logic signed [BW-1:0] v);
        logic signed [BW-1:0] c;
        c = (v > SAT_HI_B) ? SAT_HI_B : ((v < SAT_LO_B) ? SAT_LO_B : v);
        return RW'(c);
    endfunction

    // ---------------- stage 1: edge vectors and their products ----------------
    logic [F-1:0]          ax, ay, mx, my, rx, ry;
    logic signed [F:0]     bx, by, cx, cy;
    logic signed [PW-1:0]  bx_w, by_w, cx_w, cy_w;

    assign ax = F'(left_x);
    assign ay = F'(left_y);
    assign mx = F'(mid_x);
    assign my = F'(mid_y);
    assign rx = F'(right_x);
    assign ry = F'(right_y);
    assign bx = $signed({1'b0, mx}) - $signed({1'b0, ax});
    assign by = $signed({1'b0, my}) - $signed({1'b0, ay});
    assign cx = $signed({1'b0, rx}) - $signed({1'b0, ax});
    assign cy = $signed({1'b0, ry}) - $signed({1'b0, ay});
    assign bx_w = PW'(bx);
    assign by_w = PW'(by);
    assign cx_w = PW'(cx);
    assign cy_w = PW'(cy);

    logic                  v1_reg;
    logic [F-1:0]          ax1_reg, ay1_reg;
    logic signed [F:0]     bx1_reg, by1_reg, cx1_reg, cy1_reg;
    logic signed [PW-1:0]  bxcy_reg, bycx_reg, bxbx_reg, byby_reg, cxcx_reg, cycy_reg;

    always_ff @(posedge clk)
    begin
        ax1_reg  <= ax;
        ay1_reg  <= ay;
        bx1_reg  <= bx;
        by1_reg  <= by;
        cx1_reg  <= cx;
        cy1_reg  <= cy;
        bxcy_reg <= PW'(bx_w * cy_w);
        bycx_reg <= PW'(by_w * cx_w);
        bxbx_reg <= PW'(bx_w * bx_w);
        byby_reg <= PW'(by_w * by_w);
        cxcx_reg <= PW'(cx_w * cx_w);
        cycy_reg <= PW'(cy_w * cy_w);
    end

    // ---------------- stage 2: determinant and squared lengths ----------------
    logic                  v2_reg;
    logic [F-1:0]          ax2_reg, ay2_reg;
    logic signed [F:0]     bx2_reg, by2_reg, cx2_reg, cy2_reg;
    logic signed [PW-1:0]  det2_reg, b2_reg, c2_reg;

    always_ff @(posedge clk)
    begin
        ax2_reg  <= ax1_reg;
        ay2_reg  <= ay1_reg;
        bx2_reg  <= bx1_reg;
        by2_reg  <= by1_reg;
        cx2_reg  <= cx1_reg;
        cy2_reg  <= cy1_reg;
        det2_reg <= bxcy_reg - bycx_reg;
        b2_reg   <= bxbx_reg + byby_reg;
        c2_reg   <= cxcx_reg + cycy_reg;
    end

    // ---------------- stage 3: numerator partial products ----------------
    logic                  v3_reg;
    logic [F-1:0]          ax3_reg, ay3_reg;
    logic signed [PW-1:0]  det3_reg;
    logic signed [NW-1:0]  b2cy_reg, c2by_reg, c2bx_reg, b2cx_reg;

    always_ff @(posedge clk)
    begin
        ax3_reg  <= ax2_reg;
        ay3_reg  <= ay2_reg;
        det3_reg <= det2_reg;
        b2cy_reg <= NW'(NW'(b2_reg) * NW'(cy2_reg));
        c2by_reg <= NW'(NW'(c2_reg) * NW'(by2_reg));
        c2bx_reg <= NW'(NW'(c2_reg) * NW'(bx2_reg));
        b2cx_reg <= NW'(NW'(b2_reg) * NW'(cx2_reg));
    end

    // ---------------- stage 4: magnitudes, rounding bias, divisor ----------------
    // offset = round(N / 2D), ties away: floor((|N| + |D|) / 2|D|), sign applied after
    logic signed [NW-1:0]  nx, ny;
    logic [NW-1:0]         nx_mag, ny_mag;
    logic [PW-1:0]         det_mag;
    cegu_ctl_t             ctl4_next;

    always_comb
    begin
        nx              = b2cy_reg - c2by_reg;
        ny              = c2bx_reg - b2cx_reg;
        nx_mag          = nx[NW-1] ? NW'(-nx) : NW'(nx);
        ny_mag          = ny[NW-1] ? NW'(-ny) : NW'(ny);
        det_mag         = det3_reg[PW-1] ? PW'(-det3_reg) : PW'(det3_reg);
        ctl4_next.valid = v3_reg;
        ctl4_next.degen = (det3_reg == '0);
        ctl4_next.conv  = det3_reg[PW-1];
        ctl4_next.neg_x = nx[NW-1] ^ det3_reg[PW-1];
        ctl4_next.neg_y = ny[NW-1] ^ det3_reg[PW-1];
    end

    cegu_ctl_t             ctl4_reg;
    logic [F-1:0]          ax4_reg, ay4_reg;
    logic [QW-1:0]         numx4_reg, numy4_reg;
    logic [DVW-1:0]        dv4_reg;

    always_ff @(posedge clk)
    begin
        ax4_reg   <= ax3_reg;
        ay4_reg   <= ay3_reg;
        numx4_reg <= nx_mag + QW'(det_mag);
        numy4_reg <= ny_mag + QW'(det_mag);
        dv4_reg   <= DVW'({det_mag, 1'b0});
    end

    // control flops of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            ctl4_reg <= '0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            ctl4_reg <= ctl4_next;
        end
    end

    // ---------------- divider row: one quotient bit per cell ----------------
    cegu_ctl_t       dctl [0:QW];
    logic [F-1:0]    dax  [0:QW];
    logic [F-1:0]    day  [0:QW];
    logic [QW-1:0]   dnx  [0:QW];
    logic [QW-1:0]   dny  [0:QW];
    logic [QW-1:0]   dqx  [0:QW];
    logic [QW-1:0]   dqy  [0:QW];
    logic [DVW:0]    drx  [0:QW];
    logic [DVW:0]    dry  [0:QW];
    logic [DVW-1:0]  ddv  [0:QW];

    assign dctl[0] = ctl4_reg;
    assign dax[0]  = ax4_reg;
    assign day[0]  = ay4_reg;
    assign dnx[0]  = numx4_reg;
    assign dny[0]  = numy4_reg;
    assign dqx[0]  = '0;
    assign dqy[0]  = '0;
    assign drx[0]  = '0;
    assign dry[0]  = '0;
    assign ddv[0]  = dv4_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        cegu_div_cell #(
            .QW  (QW),
            .DVW (DVW),
            .CW  (F)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_in   (dctl[i]),
            .ax_in    (dax[i]),
            .ay_in    (day[i]),
            .numx_in  (dnx[i]),
            .numy_in  (dny[i]),
            .qx_in    (dqx[i]),
            .qy_in    (dqy[i]),
            .remx_in  (drx[i]),
            .remy_in  (dry[i]),
            .dv_in    (ddv[i]),
            .ctl_out  (dctl[i+1]),
            .ax_out   (dax[i+1]),
            .ay_out   (day[i+1]),
            .numx_out (dnx[i+1]),
            .numy_out (dny[i+1]),
            .qx_out   (dqx[i+1]),
            .qy_out   (dqy[i+1]),
            .remx_out (drx[i+1]),
            .remy_out (dry[i+1]),
            .dv_out   (ddv[i+1])
        );
    end

    // ---------------- stage 5: center, clamped, and offset from left site ----------------
    // A quotient beyond the result range clamps regardless, so no separate cap is needed.
    logic signed [EW-1:0]  qx_e, qy_e, ax_e, ay_e, cxs_e, cys_e;
    logic signed [RW-1:0]  cxo, cyo;

    always_comb
    begin
        qx_e  = $signed(EW'(dqx[QW]));
        qy_e  = $signed(EW'(dqy[QW]));
        ax_e  = $signed(EW'(dax[QW]));
        ay_e  = $signed(EW'(day[QW]));
        cxs_e = dctl[QW].neg_x ? (ax_e - qx_e) : (ax_e + qx_e);
        cys_e = dctl[QW].neg_y ? (ay_e - qy_e) : (ay_e + qy_e);
        cxo   = sat_e(cxs_e);
        cyo   = sat_e(cys_e);
    end

    cegu_ctl_t             ctl5_reg, ctl6_reg, ctl7_reg;
    logic signed [RW-1:0]  cx5_reg, cy5_reg, cx6_reg, cy6_reg, cx7_reg, cy7_reg;
    logic signed [RW:0]    dx5_reg, dy5_reg;
    logic [RW:0]           dxm, dym;
    logic [2*RW+1:0]       sqx6_reg, sqy6_reg;
    logic [2*SW-1:0]       n7_reg;

    // magnitude can exceed 2^(RW-1) past a low clamp, so keep all RW+1 bits
    assign dxm = dx5_reg[RW] ? (RW+1)'(-dx5_reg) : (RW+1)'(dx5_reg);
    assign dym = dy5_reg[RW] ? (RW+1)'(-dy5_reg) : (RW+1)'(dy5_reg);

    always_ff @(posedge clk)
    begin
        cx5_reg  <= cxo;
        cy5_reg  <= cyo;
        dx5_reg  <= (RW+1)'(cxo) - (RW+1)'($signed({1'b0, dax[QW]}));
        dy5_reg  <= (RW+1)'(cyo) - (RW+1)'($signed({1'b0, day[QW]}));
        // stage 6: squares of the offsets
        cx6_reg  <= cx5_reg;
        cy6_reg  <= cy5_reg;
        sqx6_reg <= (2*RW+2)'(dxm) * (2*RW+2)'(dxm);
        sqy6_reg <= (2*RW+2)'(dym) * (2*RW+2)'(dym);
        // stage 7: squared radius
        cx7_reg  <= cx6_reg;
        cy7_reg  <= cy6_reg;
        n7_reg   <= (2*SW)'(sqx6_reg) + (2*SW)'(sqy6_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl5_reg <= '0;
            ctl6_reg <= '0;
            ctl7_reg <= '0;
        end
        else
        begin
            ctl5_reg <= dctl[QW];
            ctl6_reg <= ctl5_reg;
            ctl7_reg <= ctl6_reg;
        end
    end

    // ---------------- square root row: one root bit per cell ----------------
    cegu_ctl_t         sctl [0:SW];
    logic [RW-1:0]     scx  [0:SW];
    logic [RW-1:0]     scy  [0:SW];
    logic [2*SW-1:0]   sn   [0:SW];
    logic [SW+1:0]     srem [0:SW];
    logic [SW-1:0]     sres [0:SW];

    assign sctl[0] = ctl7_reg;
    assign scx[0]  = cx7_reg;
    assign scy[0]  = cy7_reg;
    assign sn[0]   = n7_reg;
    assign srem[0] = '0;
    assign sres[0] = '0;

    for (genvar j = 0; j < SW; j++)
    begin : g_sqrt
        cegu_sqrt_cell #(
            .SW (SW),
            .RW (RW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (sctl[j]),
            .cx_in   (scx[j]),
            .cy_in   (scy[j]),
            .n_in    (sn[j]),
            .rem_in  (srem[j]),
            .res_in  (sres[j]),
            .ctl_out (sctl[j+1]),
            .cx_out  (scx[j+1]),
            .cy_out  (scy[j+1]),
            .n_out   (sn[j+1]),
            .rem_out (srem[j+1]),
            .res_out (sres[j+1])
        );
    end

    // ---------------- stage 8: lowest point and output register ----------------
    logic signed [BW-1:0]  bot_w;
    logic                  strobe_reg;
    logic                  conv_reg, degen_reg;
    logic signed [RW-1:0]  cx_out_reg, cy_out_reg, by_out_reg;
    cegu_ctl_t             fctl;

    assign fctl  = sctl[SW];
    assign bot_w = BW'($signed(scy[SW])) - $signed(BW'(sres[SW]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= fctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        degen_reg  <= fctl.degen;
        conv_reg   <= fctl.conv & ~fctl.degen;
        cx_out_reg <= fctl.degen ? '0 : $signed(scx[SW]);
        cy_out_reg <= fctl.degen ? '0 : $signed(scy[SW]);
        by_out_reg <= fctl.degen ? '0 : sat_b(bot_w);
    end

    assign busy       = 1'b0;
    assign strobe     = strobe_reg;
    assign converges  = conv_reg;
    assign degenerate = degen_reg;
    assign center_x   = cx_out_reg;
    assign center_y   = cy_out_reg;
    assign bottom_y   = by_out_reg;

endmodule

>>> rtl/cegu_checker.sv
// Port-level checks for the circle event geometry unit, bound to the top level.
`include "circle_event_geometry_unit_defines.svh"

module cegu_checker
    import cegu_pkg::*;
#(
    parameter int RESULT_WIDTH = RESULT_WIDTH_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           busy,
    input logic                           strobe,
    input logic                           converges,
    input logic                           degenerate,
    input logic signed [RESULT_WIDTH-1:0] center_x,
    input logic signed [RESULT_WIDTH-1:0] center_y,
    input logic signed [RESULT_WIDTH-1:0] bottom_y
);

    logic degen_clean;

    assign degen_clean = !converges && center_x == '0 && center_y == '0 && bottom_y == '0;

    // fully pipelined: never refuses a transfer
    `CEGU_ASSERT_NEVER(a_never_busy, clk, rst_n, busy)

    // collinear sites carry zero centers and no convergence
    `CEGU_ASSERT_IMPLY(a_degen_zero, clk, rst_n, strobe && degenerate, degen_clean)

    // radius is never negative, so the low point sits at or below the center
    `CEGU_ASSERT_IMPLY(a_bottom_below, clk, rst_n, strobe && !degenerate, bottom_y <= center_y)

endmodule

bind circle_event_geometry_unit cegu_checker #(
    .RESULT_WIDTH (RESULT_WIDTH)
) u_cegu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .busy       (busy),
    .strobe     (strobe),
    .converges  (converges),
    .degenerate (degenerate),
    .center_x   (center_x),
    .center_y   (center_y),
    .bottom_y   (bottom_y)
);
